>>> sv/ivalloc_pkg.sv
// package for the interrupt vector allocator: sizes, constants, state type
`timescale 1ns / 1ps
package ivalloc_pkg;

	localparam int LINE_COUNT   = 64;
	localparam int LINE_W       = 6;
	localparam int LINE_AW      = $clog2(LINE_COUNT);
	localparam int BUCKET_COUNT = 7;
	localparam int BKT_W        = 3;
	localparam int USE_W        = 4;
	localparam int VEC_W        = 8;
	localparam int IRQL_W       = 5;
	localparam int AFF_W        = 32;

	localparam logic [USE_W-1:0] USE_MAX    = 4'd15;
	localparam logic [VEC_W-1:0] VEC_BASE   = 8'h50;
	localparam int               GROUP_SIZE = 16;
	localparam logic [AFF_W-1:0] AFF_RESET  = 32'h0000_0001;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} ivalloc_state_t;

endpackage

>>> sv/interrupt_vector_allocator_core.sv
// top level of the interrupt vector allocator
`timescale 1ns / 1ps
// Interrupt vector allocator. Each transfer on the input channel carries one
// resolved interrupt controller line; one result transfer comes back with the
// line's system vector, its priority level (irql), the current default
// affinity mask and a flag that is set when this request assigned the vector.
// The first request for a line takes the least-used of the seven vector
// buckets (ties go to the highest-numbered bucket), bumps its use count
// (saturating at 15) and stores bucket*16 + 0x50 + count for the line; later
// requests return the stored vector. The line table sits in a ram with a
// registered read, plus one valid bit per line that reset clears,
// so the table is usable right after reset with no clearing pass. An item
// goes through the table read, then the bucket choice, write-back and result
// register load. The result register lets the next line be accepted while
// a result still waits to be taken. The user must write default_affinity
// via cfg_we/cfg_wdata only while idle; the block does not enforce this.
module interrupt_vector_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ivalloc_pkg::LINE_W-1:0] line,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ivalloc_pkg::VEC_W-1:0]  vector,
	output logic [ivalloc_pkg::IRQL_W-1:0] irql,
	output logic [ivalloc_pkg::AFF_W-1:0]  affinity,
	output logic                         newly_assigned,
	// configuration
	input  logic                         cfg_we,
	input  logic [ivalloc_pkg::AFF_W-1:0]  cfg_wdata
);
	import ivalloc_pkg::*;

	ivalloc_state_t state_q, state_d;

	// request held while the table read is in flight
	logic [LINE_W-1:0]  line_s1;
	logic [AFF_W-1:0]   default_affinity_q;
	logic [LINE_COUNT-1:0] line_valid_q;
	logic [USE_W-1:0]   bucket_use_q [BUCKET_COUNT];

	// result register
	logic               out_valid_q;
	logic [VEC_W-1:0]   vector_q;
	logic [IRQL_W-1:0]  irql_q;
	logic [AFF_W-1:0]   affinity_q;
	logic               newly_assigned_q;

	logic               accept;
	logic               advance;
	logic               rd_en;
	logic [LINE_AW-1:0] rd_addr;
	logic [LINE_AW-1:0] line_idx;
	logic [VEC_W-1:0]   ram_rdata;
	logic               wr_en;

	logic               in_range;
	logic               assigned;
	logic [BKT_W-1:0]   best;
	logic [USE_W-1:0]   use_next;
	logic               fresh;
	logic [VEC_W-1:0]   vec_new;
	logic [VEC_W-1:0]   vec_res;
	logic [IRQL_W-1:0]  irql_res;

	assign accept  = in_valid && in_ready;
	// the result register is free or empties this cycle
	assign advance = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (advance) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: one item in flight, so the write-back always lands
	// before the next read of the table
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
			end
			ST_LOOKUP: begin
				wr_en = advance && fresh;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign rd_addr  = LINE_AW'(line);
	assign line_idx = LINE_AW'(line_s1);

	ivalloc_ram #(
		.WIDTH (VEC_W),
		.DEPTH (LINE_COUNT)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (line_idx),
		.wdata (vec_new),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// least-used bucket, strict compare keeps the higher bucket on ties
	always_comb begin
		best = BKT_W'(BUCKET_COUNT - 1);
		for (int i = BUCKET_COUNT - 1; i > 0; i--) begin
			if (bucket_use_q[i-1] < bucket_use_q[best]) begin
				best = BKT_W'(i - 1);
			end
		end
	end

	assign in_range = (32'(line_s1) < LINE_COUNT);
	assign assigned = line_valid_q[line_idx];
	assign fresh    = in_range && !assigned;

	// count saturates, a full bucket reuses its top vector
	assign use_next = (bucket_use_q[best] < USE_MAX) ? bucket_use_q[best] + 1'b1
		: bucket_use_q[best];
	assign vec_new  = VEC_W'(int'(best) * GROUP_SIZE) + VEC_BASE + VEC_W'(use_next);

	always_comb begin
		if (!in_range) begin
			vec_res  = '0;
			irql_res = '0;
		end else begin
			vec_res  = assigned ? ram_rdata : vec_new;
			irql_res = IRQL_W'(vec_res[VEC_W-1:4]) - IRQL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
			for (int i = 0; i < BUCKET_COUNT; i++) begin
				bucket_use_q[i] <= '0;
			end
		end else if (wr_en) begin
			line_valid_q[line_idx] <= 1'b1;
			bucket_use_q[best]     <= use_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_affinity_q <= AFF_RESET;
		end else if (cfg_we) begin
			default_affinity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_s1 <= line;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vector_q         <= vec_res;
			irql_q           <= irql_res;
			affinity_q       <= in_range ? default_affinity_q : '0;
			newly_assigned_q <= fresh;
		end
	end

	assign out_valid      = out_valid_q;
	assign vector         = vector_q;
	assign irql           = irql_q;
	assign affinity       = affinity_q;
	assign newly_assigned = newly_assigned_q;

endmodule

>>> sv/ivalloc_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module ivalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/ivalloc_chk.sv
// port-level checker for the interrupt vector allocator, with its bind
`timescale 1ns / 1ps
module ivalloc_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ivalloc_pkg::VEC_W-1:0]  vector,
	input logic [ivalloc_pkg::IRQL_W-1:0] irql,
	input logic                         newly_assigned
);
	import ivalloc_pkg::*;

	// one line in flight: no new transfer right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a lookup is pending");

	// priority always follows the vector group
	a_irql_group: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && vector != '0) |-> (irql == IRQL_W'(vector[VEC_W-1:4]) - IRQL_W'(1)))
		else $error("irql does not match vector group");

	// a fresh assignment never yields the unassigned code
	a_fresh_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && newly_assigned) |-> (vector != '0))
		else $error("new vector is zero");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(vector)))
		else $error("result changed while stalled");

endmodule

bind interrupt_vector_allocator_core ivalloc_chk u_ivalloc_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.vector         (vector),
	.irql           (irql),
	.newly_assigned (newly_assigned)
);
